/* hw/rtl/ggm_pkg.sv */
// ----------------------------------------------------------------------------
// Gray gradient magnitude package
// Shared widths, register codes, line buffer and result types, and the small
// arithmetic helpers used by the gradient core.
// ----------------------------------------------------------------------------
`default_nettype none

package ggm_pkg;

  // Line buffer geometry.
  localparam int MAX_WIDTH = 2048;
  localparam int COL_W     = $clog2(MAX_WIDTH);

  // Field and register widths.
  localparam int PIX_W    = 8;
  localparam int ROW_W    = 16;
  localparam int FWIDTH_W = 12;
  localparam int SUM_W    = 15;
  localparam int DATA_W   = 32;
  localparam int ADDR_W   = 3;

  // Luma weights in hundredths.
  localparam int WEIGHT_RED   = 30;
  localparam int WEIGHT_GREEN = 59;
  localparam int WEIGHT_BLUE  = 11;

  // Division by one hundred as a multiply by 5243 and a shift by 19.
  // The error stays below one hundredth over the whole sum range.
  localparam int RECIP_W     = 13;
  localparam int RECIP       = 5243;
  localparam int RECIP_SHIFT = 19;
  localparam int PROD_W      = SUM_W + RECIP_W;

  // Reset values of the configuration registers.
  localparam logic [FWIDTH_W-1:0] FRAME_WIDTH_RESET  = 12'd640;
  localparam logic [ROW_W-1:0]    FRAME_HEIGHT_RESET = 16'd480;

  // Result queue geometry.
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

  // Register index, taken from bit 2 of the byte address.
  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_idx_t;

  // One line buffer entry: gray of the row above and of the row two above.
  typedef struct packed {
    logic [PIX_W-1:0] prev;
    logic [PIX_W-1:0] older;
  } line_entry_t;

  // One result word.
  typedef struct packed {
    logic [PIX_W-1:0] magnitude;
    logic             run_last;
    logic             frame_done;
  } result_t;

  // Weighted colour sum to gray level, floor(sum / 100).
  function automatic logic [PIX_W-1:0] gray_of_sum(input logic [SUM_W-1:0] sum);
    logic [PROD_W-1:0] prod;
    prod = PROD_W'(sum) * PROD_W'(RECIP);
    return prod[RECIP_SHIFT +: PIX_W];
  endfunction

  // Half of the absolute difference of two gray levels, truncated.
  function automatic logic [PIX_W-2:0] half_abs_diff(input logic [PIX_W-1:0] a,
                                                     input logic [PIX_W-1:0] b);
    logic [PIX_W-1:0] d;
    d = (a >= b) ? (a - b) : (b - a);
    return d[PIX_W-1:1];
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/gray_gradient_magnitude_core.sv */
// ----------------------------------------------------------------------------
// Gray gradient magnitude core
// Converts a raster RGB stream to gray and outputs the L1 central-difference
// gradient magnitude of the row above, with zero on the frame border.
// ----------------------------------------------------------------------------
// Usage:
//   The pixel channel (pix_valid/pix_ready) takes one RGB word in raster order.
//   The result channel (res_valid/res_ready) gives magnitude, run_last and
//   frame_done. The word for pixel (row-1, col) leaves with pixel (row, col);
//   row 0 gives no word, and on the last row each pixel also gives its own
//   zero word, so such a pixel causes two result words.
//   A result word passes the stage-two registers and is written to the queue;
//   it is offered as soon as it is written when no older word waits there.
//   Throughput: one pixel per cycle while the queue has room; on the last row
//   each pixel gives two words, and the single result port sets the pace.
//   Both line buffers sit in one 2048 x 16 RAM; each pixel reads the entry of
//   the following column and writes its own in the next cycle, so a small
//   register window and a forward path supply the neighbours.
//   The four-word result queue lets pixels flow while a word waits; when the
//   receiver stalls, pix_ready drops once the queue cannot take two more.
//   Reset clears the counters, the queue and the registers (width 640,
//   height 480). The line buffers are not cleared; no clearing pass runs.
//   frame_width and frame_height sit at byte addresses 0 and 4.
// ----------------------------------------------------------------------------
`default_nettype none

module gray_gradient_magnitude_core (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // APB configuration port
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [ggm_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [ggm_pkg::DATA_W-1:0]  pwdata,
  output      logic [ggm_pkg::DATA_W-1:0]  prdata,
  output      logic                        pready,
  // Pixel channel
  input  wire logic                        pix_valid,
  output      logic                        pix_ready,
  input  wire logic [ggm_pkg::PIX_W-1:0]   red,
  input  wire logic [ggm_pkg::PIX_W-1:0]   green,
  input  wire logic [ggm_pkg::PIX_W-1:0]   blue,
  // Result channel
  output      logic                        res_valid,
  input  wire logic                        res_ready,
  output      logic [ggm_pkg::PIX_W-1:0]   magnitude,
  output      logic                        run_last,
  output      logic                        frame_done
);

  // Configuration registers.
  logic [ggm_pkg::FWIDTH_W-1:0] frame_width;
  logic [ggm_pkg::ROW_W-1:0]    frame_height;
  ggm_pkg::reg_idx_t            reg_idx;
  logic                         cfg_write;

  // Raster counters and their derived flags.
  logic [ggm_pkg::COL_W-1:0]    col_cnt;
  logic [ggm_pkg::ROW_W-1:0]    row_cnt;
  logic [ggm_pkg::FWIDTH_W-1:0] width_eff;
  logic [ggm_pkg::ROW_W-1:0]    height_eff;
  logic                         last_col;
  logic                         last_row;
  logic                         border;
  logic                         emit_row;
  logic [ggm_pkg::COL_W-1:0]    next_col;
  logic [ggm_pkg::SUM_W-1:0]    color_sum;
  logic                         accept;

  // Second stage: the pixel accepted in the previous cycle.
  logic                         s2_valid;
  logic [ggm_pkg::COL_W-1:0]    s2_col;
  logic [ggm_pkg::SUM_W-1:0]    s2_sum;
  logic                         s2_border;
  logic                         s2_emit;
  logic                         s2_last_row;
  logic                         s2_last_col;
  logic                         s2_same;
  logic                         s2_fwd;
  ggm_pkg::line_entry_t         s2_fwd_data;

  // Line buffer access and neighbour window.
  logic [$bits(ggm_pkg::line_entry_t)-1:0] ram_rdata;
  ggm_pkg::line_entry_t         rd_entry;
  ggm_pkg::line_entry_t         wr_entry;
  ggm_pkg::line_entry_t         win;
  logic [ggm_pkg::PIX_W-1:0]    west_gray;
  logic [ggm_pkg::PIX_W-1:0]    gray;
  logic [ggm_pkg::PIX_W-2:0]    half_ew;
  logic [ggm_pkg::PIX_W-2:0]    half_sn;
  logic [ggm_pkg::PIX_W-1:0]    mag;

  // Result queue.
  ggm_pkg::result_t             res_mem [ggm_pkg::FIFO_DEPTH];
  logic [ggm_pkg::FIFO_PTR_W-1:0] wr_ptr;
  logic [ggm_pkg::FIFO_PTR_W-1:0] rd_ptr;
  logic [ggm_pkg::FIFO_CNT_W-1:0] fifo_cnt;
  logic                         push_row;
  logic                         push_own;
  ggm_pkg::result_t             row_word;
  ggm_pkg::result_t             own_word;
  logic [1:0]                   s2_words;
  logic                         pop;

  // Register decode and read-back.
  assign pready    = 1'b1;
  assign reg_idx   = ggm_pkg::reg_idx_t'(paddr[2]);
  assign cfg_write = psel & penable & pwrite;

  always_comb begin
    unique case (reg_idx)
      ggm_pkg::REG_FRAME_WIDTH:  prdata = ggm_pkg::DATA_W'(frame_width);
      ggm_pkg::REG_FRAME_HEIGHT: prdata = ggm_pkg::DATA_W'(frame_height);
      default:                   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= ggm_pkg::FRAME_WIDTH_RESET;
      frame_height <= ggm_pkg::FRAME_HEIGHT_RESET;
    end else if (cfg_write) begin
      unique case (reg_idx)
        ggm_pkg::REG_FRAME_WIDTH:  frame_width  <= pwdata[ggm_pkg::FWIDTH_W-1:0];
        ggm_pkg::REG_FRAME_HEIGHT: frame_height <= pwdata[ggm_pkg::ROW_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective frame size: zero counts as one, the width saturates at the
  // line buffer depth.
  always_comb begin
    if (frame_width == '0) begin
      width_eff = ggm_pkg::FWIDTH_W'(1);
    end else if (frame_width > ggm_pkg::FWIDTH_W'(ggm_pkg::MAX_WIDTH)) begin
      width_eff = ggm_pkg::FWIDTH_W'(ggm_pkg::MAX_WIDTH);
    end else begin
      width_eff = frame_width;
    end
    height_eff = (frame_height == '0) ? ggm_pkg::ROW_W'(1) : frame_height;
  end

  // Position flags of the pixel on offer.
  assign last_col = ({1'b0, col_cnt} + ggm_pkg::FWIDTH_W'(1)) >= width_eff;
  assign last_row = ({1'b0, row_cnt} + (ggm_pkg::ROW_W + 1)'(1)) >= {1'b0, height_eff};
  assign emit_row = (row_cnt != '0);
  assign border   = (col_cnt == '0) || last_col || (row_cnt == ggm_pkg::ROW_W'(1))
                    || (row_cnt >= height_eff);
  assign next_col = last_col ? '0 : col_cnt + ggm_pkg::COL_W'(1);

  // Weighted colour sum; the division by one hundred follows in stage two.
  assign color_sum = ggm_pkg::SUM_W'(red)   * ggm_pkg::SUM_W'(ggm_pkg::WEIGHT_RED)
                   + ggm_pkg::SUM_W'(green) * ggm_pkg::SUM_W'(ggm_pkg::WEIGHT_GREEN)
                   + ggm_pkg::SUM_W'(blue)  * ggm_pkg::SUM_W'(ggm_pkg::WEIGHT_BLUE);

  // Accept while the queue has room for this pixel's results and the one ahead.
  assign s2_words  = s2_valid ? (2'(s2_emit) + 2'(s2_last_row)) : 2'd0;
  assign pix_ready = (fifo_cnt + ggm_pkg::FIFO_CNT_W'(s2_words))
                     <= ggm_pkg::FIFO_CNT_W'(2);
  assign accept    = pix_valid & pix_ready;

  // Raster counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt <= '0;
      row_cnt <= '0;
    end else if (accept) begin
      if (last_col) begin
        col_cnt <= '0;
        row_cnt <= last_row ? '0 : row_cnt + ggm_pkg::ROW_W'(1);
      end else begin
        col_cnt <= col_cnt + ggm_pkg::COL_W'(1);
      end
    end
  end

  // Stage one to stage two. The read of the next column's entry is forwarded
  // from stage two when that entry is being written in the same cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s2_col      <= col_cnt;
      s2_sum      <= color_sum;
      s2_border   <= border;
      s2_emit     <= emit_row;
      s2_last_row <= last_row;
      s2_last_col <= last_col;
      s2_same     <= (next_col == col_cnt);
      s2_fwd      <= s2_valid && (s2_col == next_col);
      s2_fwd_data <= wr_entry;
    end
  end

  // Both line buffers live in one RAM, one entry per column.
  ggm_ram #(
    .WIDTH ($bits(ggm_pkg::line_entry_t)),
    .DEPTH (ggm_pkg::MAX_WIDTH)
  ) u_line_ram (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (next_col),
    .rd_data (ram_rdata),
    .wr_en   (s2_valid),
    .wr_addr (s2_col),
    .wr_data (wr_entry)
  );

  // Stage two: gray level, neighbours and the write-back of this column.
  assign gray     = ggm_pkg::gray_of_sum(s2_sum);
  assign rd_entry = s2_fwd ? s2_fwd_data : ggm_pkg::line_entry_t'(ram_rdata);

  always_comb begin
    wr_entry.prev  = gray;
    wr_entry.older = win.prev;
  end

  // East from the next column of the row above, west from the older row as it
  // stands after the previous pixel, north from this column's older row.
  assign half_ew = ggm_pkg::half_abs_diff(rd_entry.prev, west_gray);
  assign half_sn = ggm_pkg::half_abs_diff(gray, win.older);
  assign mag     = {1'b0, half_ew} + {1'b0, half_sn};

  // Slide the window: the entry read now belongs to the next pixel's column.
  always_ff @(posedge clk) begin
    if (s2_valid) begin
      win       <= s2_same ? wr_entry : rd_entry;
      west_gray <= win.prev;
    end
  end

  // Result words of the pixel in stage two.
  assign push_row = s2_valid & s2_emit;
  assign push_own = s2_valid & s2_last_row;

  always_comb begin
    row_word.magnitude  = s2_border ? '0 : mag;
    row_word.run_last   = ~s2_last_row;
    row_word.frame_done = 1'b0;
    own_word.magnitude  = '0;
    own_word.run_last   = 1'b1;
    own_word.frame_done = s2_last_col;
  end

  // Queue storage; up to two words are written per cycle.
  always_ff @(posedge clk) begin
    if (push_row) begin
      res_mem[wr_ptr] <= row_word;
      if (push_own) begin
        res_mem[wr_ptr + ggm_pkg::FIFO_PTR_W'(1)] <= own_word;
      end
    end else if (push_own) begin
      res_mem[wr_ptr] <= own_word;
    end
  end

  assign pop       = res_valid & res_ready;
  assign res_valid = (fifo_cnt != '0);

  // Queue pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr   <= '0;
      rd_ptr   <= '0;
      fifo_cnt <= '0;
    end else begin
      wr_ptr   <= wr_ptr + ggm_pkg::FIFO_PTR_W'(s2_words);
      if (pop) begin
        rd_ptr <= rd_ptr + ggm_pkg::FIFO_PTR_W'(1);
      end
      fifo_cnt <= fifo_cnt + ggm_pkg::FIFO_CNT_W'(s2_words)
                  - ggm_pkg::FIFO_CNT_W'(pop);
    end
  end

  // Head of the queue drives the result fields.
  always_comb begin
    magnitude  = res_mem[rd_ptr].magnitude;
    run_last   = res_mem[rd_ptr].run_last;
    frame_done = res_mem[rd_ptr].frame_done;
  end

endmodule

`default_nettype wire

/* hw/rtl/ggm_ram.sv */
// ----------------------------------------------------------------------------
// Generic single-clock RAM
// One write port and one read port with registered read data. A read of the
// address being written in the same cycle returns the old contents.
// ----------------------------------------------------------------------------
`default_nettype none

module ggm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output      logic [WIDTH-1:0]         rd_data,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read share one clocked block.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire
